// ===== design/gmd_pkg.sv =====
package gmd_pkg;

    localparam int CFG_W     = 5;
    localparam int COORD_W   = 4;
    localparam int MARK_W    = 2;
    localparam int DIR_W     = 3;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2
    } opcode_t;

    localparam logic [MARK_W-1:0] MARK_OPEN    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_VISITED = 2'd2;
    localparam logic [MARK_W-1:0] MARK_DEAD    = 2'd3;

    localparam logic [DIR_W-1:0] DIR_N    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_E    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_S    = 3'd2;
    localparam logic [DIR_W-1:0] DIR_W_   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE = 3'd4;

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 5'd10;
    localparam logic [CFG_W-1:0] COLS_RESET = 5'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PROBE,
        ST_CHECK,
        ST_FAIL,
        ST_POP
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         opcode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [MARK_W-1:0]  cell_in;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic              reply_kind;
        logic              found;
        logic [MARK_W-1:0] cell_out;
    } rsp_t;

endpackage

// ===== design/gmd_engine.sv =====
module gmd_engine #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLS    = 16,
    parameter int STACK_DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gmd_pkg::cmd_t              cmd,
    input  logic [gmd_pkg::CFG_W-1:0]  rows_in_use,
    input  logic [gmd_pkg::CFG_W-1:0]  cols_in_use,
    output logic                       busy,
    output gmd_pkg::rsp_t              rsp
);

    localparam int RIX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RLIM_W = ($clog2(MAX_ROWS + 1) > gmd_pkg::CFG_W) ?
                            $clog2(MAX_ROWS + 1) : gmd_pkg::CFG_W;
    localparam int CLIM_W = ($clog2(MAX_COLS + 1) > gmd_pkg::CFG_W) ?
                            $clog2(MAX_COLS + 1) : gmd_pkg::CFG_W;
    localparam int RPOS_W = RLIM_W + 1;
    localparam int CPOS_W = CLIM_W + 1;
    localparam int GDEPTH = MAX_ROWS * MAX_COLS;
    localparam int GA_W   = $clog2(GDEPTH);
    localparam int SIX_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int SE_W   = RIX_W + CIX_W + gmd_pkg::DIR_W;

    gmd_pkg::state_t state_reg, state_next;

    logic [RPOS_W-1:0]           r_reg, r_next;
    logic [CPOS_W-1:0]           c_reg, c_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [gmd_pkg::COORD_W-1:0] gr_reg, gr_next;
    logic [gmd_pkg::COORD_W-1:0] gc_reg, gc_next;
    logic                        rd_ok_reg, rd_ok_next;

    logic [gmd_pkg::MARK_W-1:0] grid_mem [GDEPTH];
    logic [gmd_pkg::MARK_W-1:0] grid_q_reg;
    logic                       grid_we;
    logic [GA_W-1:0]            grid_waddr;
    logic [gmd_pkg::MARK_W-1:0] grid_wdata;
    logic                       grid_re;
    logic [GA_W-1:0]            grid_raddr;

    logic [SE_W-1:0]  stk_mem [STACK_DEPTH];
    logic [SE_W-1:0]  stk_q_reg;
    logic             stk_we;
    logic [SIX_W-1:0] stk_waddr;
    logic [SE_W-1:0]  stk_wdata;
    logic             stk_re;
    logic [SIX_W-1:0] stk_raddr;

    logic [RLIM_W-1:0] rlim;
    logic [CLIM_W-1:0] clim;
    logic              in_b;
    logic              enter_ok;
    logic              full;
    logic              at_goal;
    logic              cnt_zero;
    logic              cmd_in_store;
    logic [GA_W-1:0]   cmd_addr;
    logic [GA_W-1:0]   walk_addr;
    logic [GA_W-1:0]   pop_addr;
    logic [RIX_W-1:0]  pop_r;
    logic [CIX_W-1:0]  pop_c;
    logic [gmd_pkg::DIR_W-1:0] pop_d;
    logic [gmd_pkg::DIR_W-1:0] pop_dn;
    logic [CNT_W-1:0]  cnt_dec;

    // bounds and hit tests
    assign rlim = (RLIM_W'(rows_in_use) > RLIM_W'(MAX_ROWS)) ? RLIM_W'(MAX_ROWS)
                                                              : RLIM_W'(rows_in_use);
    assign clim = (CLIM_W'(cols_in_use) > CLIM_W'(MAX_COLS)) ? CLIM_W'(MAX_COLS)
                                                              : CLIM_W'(cols_in_use);
    assign in_b = !r_reg[RPOS_W-1] && !c_reg[CPOS_W-1] &&
                  (r_reg[RLIM_W-1:0] < rlim) && (c_reg[CLIM_W-1:0] < clim);
    assign enter_ok = (grid_q_reg == gmd_pkg::MARK_OPEN);
    assign full     = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign cnt_zero = (cnt_reg == '0);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign at_goal  = (r_reg == RPOS_W'(gr_reg)) && (c_reg == CPOS_W'(gc_reg));

    assign cmd_in_store = (32'(cmd.row) < MAX_ROWS) && (32'(cmd.col) < MAX_COLS);
    assign cmd_addr  = GA_W'(32'(cmd.row) * MAX_COLS + 32'(cmd.col));
    assign walk_addr = GA_W'(32'(r_reg[RIX_W-1:0]) * MAX_COLS + 32'(c_reg[CIX_W-1:0]));

    assign {pop_r, pop_c, pop_d} = stk_q_reg;
    assign pop_dn   = pop_d + gmd_pkg::DIR_W'(1);
    assign pop_addr = GA_W'(32'(pop_r) * MAX_COLS + 32'(pop_c));

    assign busy = (state_reg != gmd_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gmd_pkg::ST_IDLE: begin
                if (cmd.valid) begin
                    case (cmd.opcode)
                        gmd_pkg::OP_RUN:  state_next = gmd_pkg::ST_PROBE;
                        gmd_pkg::OP_READ: state_next = gmd_pkg::ST_READ;
                        default:          state_next = gmd_pkg::ST_IDLE;
                    endcase
                end
            end
            gmd_pkg::ST_READ:  state_next = gmd_pkg::ST_IDLE;
            gmd_pkg::ST_PROBE: state_next = in_b ? gmd_pkg::ST_CHECK : gmd_pkg::ST_FAIL;
            gmd_pkg::ST_CHECK: begin
                if (!enter_ok) begin
                    state_next = gmd_pkg::ST_FAIL;
                end else if (full || at_goal) begin
                    state_next = gmd_pkg::ST_IDLE;
                end else begin
                    state_next = gmd_pkg::ST_PROBE;
                end
            end
            gmd_pkg::ST_FAIL: state_next = cnt_zero ? gmd_pkg::ST_IDLE : gmd_pkg::ST_POP;
            gmd_pkg::ST_POP: begin
                if (pop_d != gmd_pkg::DIR_DONE) begin
                    state_next = gmd_pkg::ST_PROBE;
                end else if (cnt_zero) begin
                    state_next = gmd_pkg::ST_IDLE;
                end else begin
                    state_next = gmd_pkg::ST_POP;
                end
            end
            default: state_next = gmd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        r_next     = r_reg;
        c_next     = c_reg;
        cnt_next   = cnt_reg;
        gr_next    = gr_reg;
        gc_next    = gc_reg;
        rd_ok_next = rd_ok_reg;
        grid_we    = 1'b0;
        grid_waddr = walk_addr;
        grid_wdata = gmd_pkg::MARK_VISITED;
        grid_re    = 1'b0;
        grid_raddr = walk_addr;
        stk_we     = 1'b0;
        stk_waddr  = cnt_reg[SIX_W-1:0];
        stk_wdata  = {r_reg[RIX_W-1:0], c_reg[CIX_W-1:0], gmd_pkg::DIR_N};
        stk_re     = 1'b0;
        stk_raddr  = cnt_dec[SIX_W-1:0];
        rsp        = '0;
        case (state_reg)
            gmd_pkg::ST_IDLE: begin
                if (cmd.valid) begin
                    case (cmd.opcode)
                        gmd_pkg::OP_LOAD: begin
                            grid_we    = cmd_in_store;
                            grid_waddr = cmd_addr;
                            grid_wdata = cmd.cell_in;
                        end
                        gmd_pkg::OP_RUN: begin
                            r_next   = RPOS_W'(cmd.row);
                            c_next   = CPOS_W'(cmd.col);
                            gr_next  = cmd.goal_row;
                            gc_next  = cmd.goal_col;
                            cnt_next = '0;
                        end
                        gmd_pkg::OP_READ: begin
                            grid_re    = cmd_in_store;
                            grid_raddr = cmd_addr;
                            rd_ok_next = cmd_in_store;
                        end
                        default: ;
                    endcase
                end
            end
            gmd_pkg::ST_READ: begin
                rsp.valid      = 1'b1;
                rsp.reply_kind = gmd_pkg::KIND_READ;
                rsp.cell_out   = rd_ok_reg ? grid_q_reg : gmd_pkg::MARK_OPEN;
            end
            gmd_pkg::ST_PROBE: begin
                grid_re = in_b;
            end
            gmd_pkg::ST_CHECK: begin
                if (enter_ok) begin
                    grid_we = 1'b1;
                    if (full) begin
                        rsp.valid = 1'b1;
                    end else begin
                        stk_we   = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (at_goal) begin
                            rsp.valid = 1'b1;
                            rsp.found = 1'b1;
                        end else begin
                            r_next = r_reg - RPOS_W'(1);
                        end
                    end
                end
            end
            gmd_pkg::ST_FAIL: begin
                if (cnt_zero) begin
                    rsp.valid = 1'b1;
                end else begin
                    cnt_next = cnt_dec;
                    stk_re   = 1'b1;
                end
            end
            gmd_pkg::ST_POP: begin
                r_next = RPOS_W'(pop_r);
                c_next = CPOS_W'(pop_c);
                if (pop_d == gmd_pkg::DIR_DONE) begin
                    grid_we    = 1'b1;
                    grid_waddr = pop_addr;
                    grid_wdata = gmd_pkg::MARK_DEAD;
                    if (cnt_zero) begin
                        rsp.valid = 1'b1;
                    end else begin
                        cnt_next = cnt_dec;
                        stk_re   = 1'b1;
                    end
                end else begin
                    stk_we    = 1'b1;
                    stk_wdata = {pop_r, pop_c, pop_dn};
                    cnt_next  = cnt_reg + CNT_W'(1);
                    case (pop_dn)
                        gmd_pkg::DIR_E:  c_next = CPOS_W'(pop_c) + CPOS_W'(1);
                        gmd_pkg::DIR_S:  r_next = RPOS_W'(pop_r) + RPOS_W'(1);
                        gmd_pkg::DIR_W_: c_next = CPOS_W'(pop_c) - CPOS_W'(1);
                        default:         r_next = RPOS_W'(pop_r);
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gmd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg     <= r_next;
        c_reg     <= c_next;
        gr_reg    <= gr_next;
        gc_reg    <= gc_next;
        rd_ok_reg <= rd_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        if (grid_re) begin
            grid_q_reg <= grid_mem[grid_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_q_reg <= stk_mem[stk_raddr];
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_pop_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gmd_pkg::ST_POP |-> cnt_reg < CNT_W'(STACK_DEPTH))
        else $error("pop with full stack");

    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gmd_pkg::ST_IDLE && cmd.valid && cmd.opcode == gmd_pkg::OP_RUN
        |=> state_reg == gmd_pkg::ST_PROBE && cnt_reg == '0)
        else $error("run did not start with empty stack");

    a_check_after_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gmd_pkg::ST_CHECK |-> $past(state_reg == gmd_pkg::ST_PROBE))
        else $error("mark check without grid read");

endmodule

// ===== design/grid_maze_dfs_solver.sv =====
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tuser opcode; tdata row, col, cell_in, goal_row, goal_col
// m_        out  m_tvalid/m_tready    tuser reply_kind; tdata found, cell_out
// cfg_wr_   in   cfg_wr_en            index 0 rows_in_use, 1 cols_in_use
//
// load writes the grid and returns no result word; read answers from the read state (registered grid read)
// run step into an open cell: probe, mark check; out of bounds: probe, fail, pop; into a
// blocked cell: probe, mark check, fail, pop; each dead cell is unwound in the pop state
// the registered grid read and stack read set the step length; no s_ word is taken during a run
// reset clears control state and loads 10 rows and 10 columns in use; grid and stack hold
// a waiting result blocks new words until taken; the result register frees in the same cycle
module grid_maze_dfs_solver #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLS    = 16,
    parameter int STACK_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // row, col, cell_in, goal_row, goal_col
    input  logic [1:0]                        s_tuser,  // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // found, cell_out
    output logic                              m_tuser,  // reply_kind
    input  logic                              cfg_wr_en,
    input  logic [gmd_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [gmd_pkg::CFG_W-1:0]         cfg_wr_data
);

    logic [gmd_pkg::CFG_W-1:0] rows_reg, rows_next;
    logic [gmd_pkg::CFG_W-1:0] cols_reg, cols_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_kind_reg, m_kind_next;
    logic                       m_found_reg, m_found_next;
    logic [gmd_pkg::MARK_W-1:0] m_cell_reg, m_cell_next;

    gmd_pkg::cmd_t eng_cmd;
    gmd_pkg::rsp_t eng_rsp;
    logic          eng_busy;

    assign s_tready = !eng_busy && (!m_valid_reg || m_tready);

    assign eng_cmd.valid    = s_tvalid && s_tready;
    assign eng_cmd.opcode   = s_tuser;
    assign eng_cmd.row      = s_tdata[3:0];
    assign eng_cmd.col      = s_tdata[7:4];
    assign eng_cmd.cell_in  = s_tdata[9:8];
    assign eng_cmd.goal_row = s_tdata[13:10];
    assign eng_cmd.goal_col = s_tdata[17:14];

    gmd_engine #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (eng_cmd),
        .rows_in_use (rows_reg),
        .cols_in_use (cols_reg),
        .busy        (eng_busy),
        .rsp         (eng_rsp)
    );

    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                gmd_pkg::REG_ROWS_IN_USE: rows_next = cfg_wr_data;
                gmd_pkg::REG_COLS_IN_USE: cols_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    // result word register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_found_next = m_found_reg;
        m_cell_next  = m_cell_reg;
        if (eng_rsp.valid) begin
            m_valid_next = 1'b1;
            m_kind_next  = eng_rsp.reply_kind;
            m_found_next = eng_rsp.found;
            m_cell_next  = eng_rsp.cell_out;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= gmd_pkg::ROWS_RESET;
            cols_reg    <= gmd_pkg::COLS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            rows_reg    <= rows_next;
            cols_reg    <= cols_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg  <= m_kind_next;
        m_found_reg <= m_found_next;
        m_cell_reg  <= m_cell_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {5'd0, m_cell_reg, m_found_reg};

    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_rsp.valid |-> !m_valid_reg)
        else $error("result overwrites waiting word");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_busy |-> !eng_cmd.valid)
        else $error("word accepted during search");

    a_run_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_rsp.valid && eng_rsp.reply_kind == gmd_pkg::KIND_SEARCH |-> eng_rsp.cell_out == '0)
        else $error("search result carries a mark");

endmodule
